// ----- design/assert_macros.svh -----
// Assertion macros used by the top level of the phase generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk_s, rst_ns, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (prop)) \
        else $error("assertion failed: lbl");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk_s, rst_ns, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) !(cond)) \
        else $error("assertion failed: lbl");

`else

`define ASSERT_CLK(lbl, clk_s, rst_ns, prop)
`define ASSERT_NEVER(lbl, clk_s, rst_ns, cond)

`endif

`endif

// ----- design/fmopg_pkg.sv -----
// Package with types, register indexes and lookup tables of the phase generator.
`timescale 1ns / 1ps

package fmopg_pkg;

    localparam int unsigned FNUM_W    = 14;
    localparam int unsigned DETUNE_W  = 3;
    localparam int unsigned MULT_W    = 4;
    localparam int unsigned SENS_W    = 3;
    localparam int unsigned PM_W      = 5;
    localparam int unsigned PHASE_W   = 32;
    localparam int unsigned KEY_W     = 5;
    localparam int unsigned STEP_W    = 21;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 14;
    localparam int unsigned S_DATA_W  = 8;
    localparam int unsigned M_DATA_W  = 40;

    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_FNUM = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DETUNE     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MULTIPLE   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PM_SENS    = 2'd3;

    typedef struct packed {
        logic [FNUM_W-1:0]   block_and_fnum;
        logic [DETUNE_W-1:0] detune_sel;
        logic [MULT_W-1:0]   freq_multiple;
        logic [SENS_W-1:0]   pm_sensitivity;
    } fmopg_cfg_t;

    localparam logic [1:0] KC_GROUP [0:15] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1,
        2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3
    };

    localparam logic [4:0] DT_TABLE [0:7][0:3][0:3] = '{
        '{'{5'd0, 5'd0, 5'd1, 5'd2},  '{5'd0, 5'd0, 5'd1, 5'd2},
          '{5'd0, 5'd0, 5'd1, 5'd2},  '{5'd0, 5'd0, 5'd1, 5'd2}},
        '{'{5'd0, 5'd1, 5'd2, 5'd2},  '{5'd0, 5'd1, 5'd2, 5'd3},
          '{5'd0, 5'd1, 5'd2, 5'd3},  '{5'd0, 5'd1, 5'd2, 5'd3}},
        '{'{5'd0, 5'd1, 5'd2, 5'd4},  '{5'd0, 5'd1, 5'd3, 5'd4},
          '{5'd0, 5'd1, 5'd3, 5'd4},  '{5'd0, 5'd1, 5'd3, 5'd5}},
        '{'{5'd0, 5'd2, 5'd4, 5'd5},  '{5'd0, 5'd2, 5'd4, 5'd6},
          '{5'd0, 5'd2, 5'd4, 5'd6},  '{5'd0, 5'd2, 5'd5, 5'd7}},
        '{'{5'd0, 5'd2, 5'd5, 5'd8},  '{5'd0, 5'd3, 5'd6, 5'd8},
          '{5'd0, 5'd3, 5'd6, 5'd9},  '{5'd0, 5'd3, 5'd7, 5'd10}},
        '{'{5'd0, 5'd4, 5'd8, 5'd11}, '{5'd0, 5'd4, 5'd8, 5'd12},
          '{5'd0, 5'd4, 5'd9, 5'd13}, '{5'd0, 5'd5, 5'd10, 5'd14}},
        '{'{5'd0, 5'd5, 5'd11, 5'd16}, '{5'd0, 5'd6, 5'd12, 5'd17},
          '{5'd0, 5'd6, 5'd13, 5'd19}, '{5'd0, 5'd7, 5'd14, 5'd20}},
        '{'{5'd0, 5'd8, 5'd16, 5'd22}, '{5'd0, 5'd8, 5'd16, 5'd22},
          '{5'd0, 5'd8, 5'd16, 5'd22}, '{5'd0, 5'd8, 5'd16, 5'd22}}
    };

    localparam logic [2:0] VIB_SHIFT [0:7][0:7][0:1] = '{
        '{'{3'd7, 3'd7}, '{3'd7, 3'd7}, '{3'd7, 3'd7}, '{3'd7, 3'd7},
          '{3'd7, 3'd7}, '{3'd7, 3'd7}, '{3'd7, 3'd7}, '{3'd7, 3'd7}},
        '{'{3'd7, 3'd7}, '{3'd7, 3'd7}, '{3'd7, 3'd7}, '{3'd7, 3'd7},
          '{3'd7, 3'd2}, '{3'd7, 3'd2}, '{3'd7, 3'd2}, '{3'd7, 3'd2}},
        '{'{3'd7, 3'd7}, '{3'd7, 3'd7}, '{3'd7, 3'd7}, '{3'd7, 3'd2},
          '{3'd7, 3'd2}, '{3'd7, 3'd2}, '{3'd1, 3'd7}, '{3'd1, 3'd7}},
        '{'{3'd7, 3'd7}, '{3'd7, 3'd7}, '{3'd7, 3'd2}, '{3'd7, 3'd2},
          '{3'd1, 3'd7}, '{3'd1, 3'd7}, '{3'd1, 3'd2}, '{3'd1, 3'd2}},
        '{'{3'd7, 3'd7}, '{3'd7, 3'd7}, '{3'd7, 3'd2}, '{3'd1, 3'd7},
          '{3'd1, 3'd7}, '{3'd1, 3'd7}, '{3'd1, 3'd2}, '{3'd0, 3'd7}},
        '{'{3'd7, 3'd7}, '{3'd7, 3'd7}, '{3'd1, 3'd7}, '{3'd1, 3'd2},
          '{3'd0, 3'd7}, '{3'd0, 3'd7}, '{3'd0, 3'd2}, '{3'd0, 3'd1}},
        '{'{3'd7, 3'd7}, '{3'd7, 3'd7}, '{3'd1, 3'd7}, '{3'd1, 3'd2},
          '{3'd0, 3'd7}, '{3'd0, 3'd7}, '{3'd0, 3'd2}, '{3'd0, 3'd1}},
        '{'{3'd7, 3'd7}, '{3'd7, 3'd7}, '{3'd1, 3'd7}, '{3'd1, 3'd2},
          '{3'd0, 3'd7}, '{3'd0, 3'd7}, '{3'd0, 3'd2}, '{3'd0, 3'd1}}
    };

endpackage

// ----- design/fmopg_cfg.sv -----
// Configuration register file of the phase generator.
`timescale 1ns / 1ps

module fmopg_cfg
    import fmopg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output fmopg_cfg_t            cfg
);

    fmopg_cfg_t cfg_reg;
    fmopg_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_BLOCK_FNUM: cfg_next.block_and_fnum = cfg_wdata[FNUM_W-1:0];
                REG_DETUNE:     cfg_next.detune_sel     = cfg_wdata[DETUNE_W-1:0];
                REG_MULTIPLE:   cfg_next.freq_multiple  = cfg_wdata[MULT_W-1:0];
                REG_PM_SENS:    cfg_next.pm_sensitivity = cfg_wdata[SENS_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/fmopg_step.sv -----
// Phase step computation: vibrato mix, block shift, detune and multiple.
`timescale 1ns / 1ps

module fmopg_step
    import fmopg_pkg::*;
(
    input  fmopg_cfg_t        cfg,
    input  logic [PM_W-1:0]   lfo_pm,
    output logic [STEP_W-1:0] step
);

    logic [2:0]  blk;
    logic [10:0] fn;
    logic [1:0]  grp;
    logic [4:0]  dt;
    logic [2:0]  quad;
    logic [2:0]  sens;
    logic [6:0]  top;
    logic [2:0]  sh0;
    logic [2:0]  sh1;
    logic [7:0]  vib_sum;
    logic [9:0]  vib_scaled;
    logic [7:0]  vib_q;
    logic [11:0] vib_signed;
    logic [11:0] mixed;
    logic [18:0] shifted;
    logic [16:0] base;
    logic [16:0] detuned;
    logic [4:0]  mul;
    logic [21:0] prod;

    always_comb
    begin
        blk  = cfg.block_and_fnum[13:11];
        fn   = cfg.block_and_fnum[10:0];
        grp  = KC_GROUP[fn[10:7]];
        dt   = DT_TABLE[blk][grp][cfg.detune_sel[1:0]];
        quad = lfo_pm[3] ? 3'(~lfo_pm[2:0] + 3'd1) : lfo_pm[2:0];
        sens = cfg.pm_sensitivity;
        top  = fn[10:4];
        sh0  = VIB_SHIFT[sens][quad][0];
        sh1  = VIB_SHIFT[sens][quad][1];
        vib_sum = {1'b0, top >> sh0} + {1'b0, top >> sh1};
        case (sens)
            3'd6:    vib_scaled = {1'b0, vib_sum, 1'b0};
            3'd7:    vib_scaled = {vib_sum, 2'b00};
            default: vib_scaled = {2'b00, vib_sum};
        endcase
        vib_q      = vib_scaled[9:2];
        vib_signed = lfo_pm[4] ? 12'(~{4'b0000, vib_q} + 12'd1) : {4'b0000, vib_q};
        mixed      = vib_signed + {fn, 1'b0};
        shifted    = {7'b0000000, mixed} << blk;
        base       = shifted[18:2];
        detuned    = cfg.detune_sel[2] ? base - {12'd0, dt} : base + {12'd0, dt};
        mul        = (cfg.freq_multiple == '0) ? 5'd1 : {cfg.freq_multiple, 1'b0};
        prod       = detuned * mul;
        step       = prod[21:1];
    end

endmodule

// ----- design/fm_operator_phase_generator_unit.sv -----
// Top level of the FM operator phase generator.
//
// Input stream s_*: one transfer per sample tick. s_tdata carries lfo_pm and
// restart. Output stream m_*: one transfer per tick with the new phase and the
// key code. Configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata);
// write it only while no tick is in flight: the block itself does not enforce this.
//
// An accepted tick waits in the input register until the result register can
// take it; then the step is formed and added to the phase accumulator by the
// single add of the result stage, and the result is offered on m_*. Throughput
// is one tick per cycle while m_tready stays high.
//
// Reset clears the configuration, the accumulator and both valid flags. When
// the receiver stalls, the result register holds; the input register still
// takes one more tick, after which s_tready drops until the result leaves.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fm_operator_phase_generator_unit
    import fmopg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // lfo_pm[4:0], restart[5], zero[7:6]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // phase_out[31:0], kcode[36:32], zero[39:37]
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    fmopg_cfg_t          cfg;
    logic                in_valid_reg;
    logic [PM_W-1:0]     lfo_pm_reg;
    logic                restart_reg;
    logic                out_valid_reg;
    logic [PHASE_W-1:0]  phase_acc_reg;
    logic [PHASE_W-1:0]  phase_acc_next;
    logic [KEY_W-1:0]    kcode_reg;
    logic [STEP_W-1:0]   step;
    logic                s_xfer;
    logic                advance;

    fmopg_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fmopg_step u_step
    (
        .cfg    (cfg),
        .lfo_pm (lfo_pm_reg),
        .step   (step)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    assign phase_acc_next = (restart_reg ? '0 : phase_acc_reg)
                          + {{(PHASE_W-STEP_W){1'b0}}, step};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_acc_reg <= '0;
        end
        else
        begin
            if (s_xfer)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_acc_reg <= phase_acc_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            lfo_pm_reg  <= s_tdata[PM_W-1:0];
            restart_reg <= s_tdata[PM_W];
        end
        if (advance)
        begin
            kcode_reg <= cfg.block_and_fnum[13:9];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-PHASE_W-KEY_W){1'b0}}, kcode_reg, phase_acc_reg};

    `ASSERT_NEVER(a_ready_only_on_full, clk, rst_n,
        !s_tready && !(in_valid_reg && out_valid_reg && !m_tready))
    `ASSERT_CLK(a_restart_loads_step, clk, rst_n,
        advance && restart_reg |=> phase_acc_reg == PHASE_W'($past(step)))
    `ASSERT_CLK(a_acc_adds_step, clk, rst_n,
        advance && !restart_reg |=>
        phase_acc_reg == $past(phase_acc_reg) + PHASE_W'($past(step)))

endmodule
